// ----- design/pfi_pkg.sv -----
// Package for the palette fade interpolator: widths, command codes, register indices, helpers.
// No dependencies.
`timescale 1ns / 1ps
package pfi_pkg;
  localparam int PaletteEntriesDefault = 256;
  localparam int ChanW = 8;
  localparam int ColorW = 24;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 8;

  typedef enum logic [1:0] {
    CMD_WR_SRC = 2'd0,
    CMD_WR_TGT = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST = 3'd0,
    REG_LAST = 3'd1,
    REG_STEPS = 3'd2,
    REG_MODE = 3'd3,
    REG_FILL_R = 3'd4,
    REG_FILL_G = 3'd5,
    REG_FILL_B = 3'd6,
    REG_SPARE = 3'd7
  } reg_idx_t;

  // 6-bit fill channel widened by 255/63. Since 255 = 4*63 + 3,
  // c*255/63 = 4c + 3c/63 = 4c + c/21 exactly, and c/21 is 0..3 for c < 64.
  function automatic logic [ChanW-1:0] widen6(input logic [5:0] c);
    logic [1:0] corr;
    if (c >= 6'd63) corr = 2'd3;
    else if (c >= 6'd42) corr = 2'd2;
    else if (c >= 6'd21) corr = 2'd1;
    else corr = 2'd0;
    widen6 = {c, 2'b00} + {6'd0, corr};
  endfunction
endpackage

// ----- design/pfi_div.sv -----
// Pipelined signed divider of a 17-bit dividend by an 8-bit divisor, restoring,
// one quotient bit per stage; truncates toward zero. No dependencies.
`timescale 1ns / 1ps
module pfi_div #(
  parameter int NumW = 17
) (
  input  logic                    clk,
  input  logic signed [NumW-1:0]  num,
  input  logic [7:0]              den,
  output logic signed [NumW-1:0]  quot
);
  localparam int MagW = NumW - 1;
  logic [MagW-1:0] rem [0:MagW];
  logic [MagW-1:0] qv  [0:MagW];
  logic [MagW-1:0] mag [0:MagW];
  logic [7:0]      dv  [0:MagW];
  logic            neg [0:MagW];

  always_comb begin
    rem[0] = '0;
    qv[0] = '0;
    mag[0] = num[NumW-1] ? MagW'(-num) : num[MagW-1:0];
    dv[0] = den;
    neg[0] = num[NumW-1];
  end

  for (genvar i = 0; i < MagW; i++) begin : g_stage
    logic [MagW:0] trial;
    logic [MagW-1:0] r_next;
    always_comb begin
      r_next = {rem[i][MagW-2:0], mag[i][MagW-1-i]};
      trial = {1'b0, r_next} - {{(MagW-7){1'b0}}, dv[i]};
    end
    always_ff @(posedge clk) begin
      rem[i+1] <= trial[MagW] ? r_next : trial[MagW-1:0];
      qv[i+1] <= qv[i] | (trial[MagW] ? '0 : (MagW'(1) << (MagW-1-i)));
      mag[i+1] <= mag[i];
      dv[i+1] <= dv[i];
      neg[i+1] <= neg[i];
    end
  end

  assign quot = neg[MagW] ? -$signed({1'b0, qv[MagW]}) : $signed({1'b0, qv[MagW]});
endmodule

// ----- design/pfi_mem.sv -----
// Palette storage: source and target memories, registered read.
// Uses pfi_pkg.
`timescale 1ns / 1ps
module pfi_mem #(
  parameter int Entries = pfi_pkg::PaletteEntriesDefault,
  localparam int AW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                       clk,
  input  logic                       src_we,
  input  logic                       tgt_we,
  input  logic [AW-1:0]              waddr,
  input  logic [pfi_pkg::ColorW-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [pfi_pkg::ColorW-1:0] src_rd,
  output logic [pfi_pkg::ColorW-1:0] tgt_rd
);
  logic [pfi_pkg::ColorW-1:0] src_mem [0:Entries-1];
  logic [pfi_pkg::ColorW-1:0] tgt_mem [0:Entries-1];

  always_ff @(posedge clk) begin
    if (src_we) src_mem[waddr] <= wdata;
    src_rd <= src_mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[waddr] <= wdata;
    tgt_rd <= tgt_mem[raddr];
  end
endmodule

// ----- design/palette_fade_interpolator.sv -----
// Palette fade interpolator: takes one command per cycle (busy stays low).
// Compute path: memory read, product, 16-stage divider per channel, output
// register, which raises done;
// the result is held one cycle on done. Writes give no result.
// Throughput: one item per clock; the receiver cannot stall results.
// Sync reset sets config registers to their defaults and clears pipeline valids; palettes are
// undefined until written. Uses pfi_pkg, pfi_mem, pfi_div.
`timescale 1ns / 1ps
module palette_fade_interpolator #(
  parameter int PaletteEntries = pfi_pkg::PaletteEntriesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] entry_index,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] fade_step,
  input  logic       cfg_we,
  input  logic [pfi_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pfi_pkg::CfgDataW-1:0] cfg_data,
  output logic       done,
  output logic [7:0] entry_out,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       in_window
);
  localparam int AW = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;
  localparam int NumW = 17;
  localparam int DivLat = NumW - 1;

  logic [7:0] first_entry, last_entry, step_count;
  logic       goal_mode;
  logic [5:0] fill_red, fill_green, fill_blue;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_entry <= 8'd0;
      last_entry <= 8'd255;
      step_count <= 8'd30;
      goal_mode <= 1'b0;
      fill_red <= '0;
      fill_green <= '0;
      fill_blue <= '0;
    end else if (cfg_we) begin
      unique case (pfi_pkg::reg_idx_t'(cfg_index))
        pfi_pkg::REG_FIRST:  first_entry <= cfg_data;
        pfi_pkg::REG_LAST:   last_entry <= cfg_data;
        pfi_pkg::REG_STEPS:  step_count <= cfg_data;
        pfi_pkg::REG_MODE:   goal_mode <= cfg_data[0];
        pfi_pkg::REG_FILL_R: fill_red <= cfg_data[5:0];
        pfi_pkg::REG_FILL_G: fill_green <= cfg_data[5:0];
        pfi_pkg::REG_FILL_B: fill_blue <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Decode the transfer.
  logic accept, idx_ok, is_comp;
  assign accept = start && !busy;
  assign idx_ok = 32'(entry_index) < PaletteEntries;
  assign is_comp = accept && (pfi_pkg::cmd_t'(cmd) == pfi_pkg::CMD_COMPUTE);

  logic [AW-1:0] addr;
  assign addr = entry_index[AW-1:0];

  logic [pfi_pkg::ColorW-1:0] src_rd, tgt_rd;
  pfi_mem #(.Entries(PaletteEntries)) u_mem (
    .clk(clk),
    .src_we(accept && idx_ok && (pfi_pkg::cmd_t'(cmd) == pfi_pkg::CMD_WR_SRC)),
    .tgt_we(accept && idx_ok && (pfi_pkg::cmd_t'(cmd) == pfi_pkg::CMD_WR_TGT)),
    .waddr(addr),
    .wdata({red_in, green_in, blue_in}),
    .raddr(addr),
    .src_rd(src_rd),
    .tgt_rd(tgt_rd)
  );

  // Stage 1: capture command side data; memory read in flight.
  // A write lands at its accepting edge, so a compute in the cycle after it on the
  // same entry already reads the new data; no forwarding is needed.
  logic       s1_valid, s1_ok, s1_win;
  logic [7:0] s1_idx, s1_step;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= is_comp;
    s1_idx <= entry_index;
    s1_step <= fade_step;
    s1_ok <= idx_ok;
    s1_win <= (entry_index >= first_entry) && (entry_index <= last_entry);
  end
  logic [pfi_pkg::ColorW-1:0] src_c, tgt_c, goal_c;
  assign src_c = s1_ok ? src_rd : '0;
  assign tgt_c = s1_ok ? tgt_rd : '0;
  assign goal_c = goal_mode ? tgt_c
      : {pfi_pkg::widen6(fill_red), pfi_pkg::widen6(fill_green),
         pfi_pkg::widen6(fill_blue)};

  logic s1_full;
  assign s1_full = (step_count == 8'd0) || (s1_step >= step_count) || !s1_win;

  // Stage 2: products (goal - source) * step per channel.
  logic                      s2_valid, s2_win, s2_full;
  logic [7:0]                s2_idx;
  logic [pfi_pkg::ColorW-1:0] s2_src, s2_goal;
  logic signed [NumW-1:0]    s2_prod [0:2];
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
    s2_idx <= s1_idx;
    s2_win <= s1_win;
    s2_full <= s1_full;
    s2_src <= src_c;
    s2_goal <= s1_win ? goal_c : src_c;
  end
  for (genvar c = 0; c < 3; c++) begin : g_prod
    logic signed [9:0] diff;
    logic signed [NumW-1:0] prod;
    assign diff = $signed({2'b00, goal_c[8*c +: 8]}) - $signed({2'b00, src_c[8*c +: 8]});
    // Full-width signed product: operands extend to NumW bits before the multiply.
    assign prod = diff * $signed({1'b0, s1_step});
    always_ff @(posedge clk) begin
      s2_prod[c] <= prod;
    end
  end

  // Divider pipelines; side data travels in a delay line alongside.
  logic signed [NumW-1:0] quot [0:2];
  for (genvar c = 0; c < 3; c++) begin : g_div
    pfi_div #(.NumW(NumW)) u_div (
      .clk(clk), .num(s2_prod[c]), .den(step_count), .quot(quot[c])
    );
  end

  logic                      dl_valid [0:DivLat];
  logic                      dl_win   [0:DivLat];
  logic                      dl_full  [0:DivLat];
  logic [7:0]                dl_idx   [0:DivLat];
  logic [pfi_pkg::ColorW-1:0] dl_src  [0:DivLat];
  logic [pfi_pkg::ColorW-1:0] dl_goal [0:DivLat];
  always_comb begin
    dl_valid[0] = s2_valid;
    dl_win[0] = s2_win;
    dl_full[0] = s2_full;
    dl_idx[0] = s2_idx;
    dl_src[0] = s2_src;
    dl_goal[0] = s2_goal;
  end
  for (genvar i = 0; i < DivLat; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) dl_valid[i+1] <= 1'b0;
      else dl_valid[i+1] <= dl_valid[i];
      dl_win[i+1] <= dl_win[i];
      dl_full[i+1] <= dl_full[i];
      dl_idx[i+1] <= dl_idx[i];
      dl_src[i+1] <= dl_src[i];
      dl_goal[i+1] <= dl_goal[i];
    end
  end

  // Final add and clamp (or the goal colour when the fade is full), then the output register.
  logic [7:0] res [0:2];
  for (genvar c = 0; c < 3; c++) begin : g_fin
    logic signed [NumW:0] sum;
    always_comb begin
      sum = $signed({{(NumW-7){1'b0}}, dl_src[DivLat][8*c +: 8]}) +
            $signed({quot[c][NumW-1], quot[c]});
      if (dl_full[DivLat]) res[c] = dl_goal[DivLat][8*c +: 8];
      else if (sum < 0) res[c] = 8'd0;
      else if (sum > 255) res[c] = 8'd255;
      else res[c] = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dl_valid[DivLat];
    entry_out <= dl_idx[DivLat];
    in_window <= dl_win[DivLat];
    red_out <= res[2];
    green_out <= res[1];
    blue_out <= res[0];
  end
endmodule
